// ===== rtl/upd_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the URL
// percent decoder. No dependencies; imported by every module of the block.
package upd_pkg;

    // Default depth of the queue between the front and back parts
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Characters with special meaning in the encoded stream
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Digit bases used when turning a hex character into a nibble
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] UC_BIAS  = 8'h37;   // 'A' - 10
    localparam logic [7:0] LC_BIAS  = 8'h57;   // 'a' - 10

    // Configuration register map (index taken from the word address)
    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;
    localparam logic [15:0] LIMIT_RESET     = 16'hFFFF;

    // Most bytes one input byte can produce
    localparam int unsigned MAX_BYTES = 3;

    // One queue entry: the decoded bytes of one input byte, lowest first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [1:0]                cnt;
        logic                      last;
    } upd_entry_t;

    // Hex character to {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = c - UC_BIAS;
            return {1'b1, d[3:0]};
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = c - LC_BIAS;
            return {1'b1, d[3:0]};
        end
        return {1'b0, d[3:0]};
    endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// URL percent decoder, top level: configuration port, front part, queue
// and back part. Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage: encoded bytes enter on the s_ channel, one per request, with
// s_tlast on the final byte of a message. '+' becomes a space, '%' with two
// hex digits becomes one byte, anything else passes unchanged. Results leave
// on the m_ channel: tdata holds the byte, tuser[0] marks a bare end marker,
// tuser[1] says the output limit cut the message short, tlast ends it.
// output_limit is written over the APB port at byte address 0.
// A result passes through the queue and then the registered m_ channel.
// Throughput: one input byte per cycle while each byte yields at most one
// result and the receiver keeps up; the back part emits one result per cycle
// while m_tready allows, so a byte that yields two or three results (a broken
// escape) holds it longer; the QUEUE_DEPTH-entry queue absorbs the difference.
// A stalled receiver holds the registered result; the queue keeps filling
// and s_tready drops only when it is full.
// Reset empties the queue, clears the escape state and sets output_limit
// to 65535.
module url_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // encoded input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    // decoded output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] no_data, [1] truncated
    output logic        m_tlast,   // end_of_message
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import upd_pkg::*;

    logic [15:0] limit_reg;
    logic        cfg_wr;
    logic        push, q_full, head_valid, pop;
    upd_entry_t  push_entry, head;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OUTPUT_LIMIT);
    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {16'h0000, limit_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr) begin
            limit_reg <= pwdata[15:0];
        end
    end

    upd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    upd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .output_limit (limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

// ===== rtl/upd_front.sv =====
// Front part: accepts encoded bytes, tracks the escape state and hands the
// bytes each input causes to the queue. Depends on upd_pkg.
module upd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output upd_pkg::upd_entry_t push_entry
);
    import upd_pkg::*;

    logic       pending_reg, pending_next;
    logic       held_reg, held_next;
    logic [7:0] la_reg, la_next;

    logic                      accept;
    logic                      do_fresh;
    logic [1:0]                n;
    logic [MAX_BYTES-1:0][7:0] lst;
    logic [4:0]                hb, hl;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign hb       = hex_decode(s_tdata);
    assign hl       = hex_decode(la_reg);

    // Escape tracking and byte list for the current request
    always_comb begin
        pending_next = pending_reg;
        held_next    = held_reg;
        la_next      = la_reg;
        do_fresh     = 1'b0;
        n            = 2'd0;
        lst          = '0;

        if (!pending_reg) begin
            do_fresh = 1'b1;
        end else if (!held_reg) begin
            if (hb[4]) begin
                la_next   = s_tdata;
                held_next = 1'b1;
            end else begin
                lst[n]       = CH_PCT;
                n            = n + 2'd1;
                pending_next = 1'b0;
                do_fresh     = 1'b1;
            end
        end else begin
            pending_next = 1'b0;
            held_next    = 1'b0;
            if (hl[4] && hb[4]) begin
                lst[n] = {hl[3:0], hb[3:0]};
                n      = n + 2'd1;
            end else begin
                lst[n]   = CH_PCT;
                n        = n + 2'd1;
                lst[n]   = la_reg;
                n        = n + 2'd1;
                do_fresh = 1'b1;
            end
        end

        // byte scanned as plain text
        if (do_fresh) begin
            if (s_tdata == CH_PLUS) begin
                lst[n] = CH_SPACE;
                n      = n + 2'd1;
            end else if (s_tdata == CH_PCT) begin
                pending_next = 1'b1;
                held_next    = 1'b0;
            end else begin
                lst[n] = s_tdata;
                n      = n + 2'd1;
            end
        end

        // message ends inside an escape: flush what is held
        if (s_tlast && pending_next) begin
            lst[n] = CH_PCT;
            n      = n + 2'd1;
            if (held_next) begin
                lst[n] = la_next;
                n      = n + 2'd1;
            end
            pending_next = 1'b0;
            held_next    = 1'b0;
        end
    end

    assign push            = accept && (n != 2'd0 || s_tlast);
    assign push_entry.data = lst;
    assign push_entry.cnt  = n;
    assign push_entry.last = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= 1'b0;
        end else if (accept) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            la_reg <= la_next;
        end
    end

endmodule

// ===== rtl/upd_queue.sv =====
// Short queue of decoded-byte entries between the front and back parts.
// Depends on upd_pkg.
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  upd_pkg::upd_entry_t push_entry,
    output logic                full,
    output logic                head_valid,
    output upd_pkg::upd_entry_t head,
    input  logic                pop
);
    import upd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

    upd_entry_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // fill level stays within the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill level beyond depth");

    // the front never offers an entry while the queue is full
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

endmodule

// ===== rtl/upd_back.sv =====
// Back part: takes queue entries byte by byte, applies the output limit,
// marks the end of each message and drives the registered result channel.
// Depends on upd_pkg.
module upd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  upd_pkg::upd_entry_t head,
    output logic                pop,
    input  logic [15:0]         output_limit,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic [1:0]          m_tuser,   // [0] no_data, [1] truncated
    output logic                m_tlast
);
    import upd_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        hit_reg, hit_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic        out_free, drop, last_in, stop, load;
    logic [15:0] emitted_inc;
    logic [7:0]  o_byte;
    logic        o_nodata, o_last, o_trunc;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign drop        = (emitted_reg >= output_limit);
    assign last_in     = (idx_reg == head.cnt - 2'd1);
    assign emitted_inc = emitted_reg + 16'd1;

    // one byte of the head entry per cycle while the output register is free
    always_comb begin
        idx_next     = idx_reg;
        emitted_next = emitted_reg;
        hit_next     = hit_reg;
        pop          = 1'b0;
        load         = 1'b0;
        stop         = 1'b0;
        o_byte       = 8'h00;
        o_nodata     = 1'b0;
        o_last       = 1'b0;
        o_trunc      = 1'b0;

        if (head_valid) begin
            if (drop && !head.last) begin
                // limit reached mid-message: the whole entry is dropped
                pop      = 1'b1;
                hit_next = hit_reg | (head.cnt != 2'd0);
            end else if (out_free) begin
                if (drop || head.cnt == 2'd0) begin
                    // end marker with no byte
                    load         = 1'b1;
                    o_nodata     = 1'b1;
                    o_last       = 1'b1;
                    o_trunc      = hit_reg | (drop && head.cnt != 2'd0);
                    pop          = 1'b1;
                    idx_next     = 2'd0;
                    emitted_next = 16'd0;
                    hit_next     = 1'b0;
                end else begin
                    load         = 1'b1;
                    o_byte       = head.data[idx_reg];
                    emitted_next = emitted_inc;
                    // later bytes of this entry would all be dropped
                    stop         = last_in || (emitted_inc >= output_limit);
                    if (stop) begin
                        pop      = 1'b1;
                        idx_next = 2'd0;
                        if (head.last) begin
                            o_last       = 1'b1;
                            o_trunc      = hit_reg | !last_in;
                            emitted_next = 16'd0;
                            hit_next     = 1'b0;
                        end else begin
                            hit_next = hit_reg | !last_in;
                        end
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
        end

        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            emitted_reg  <= 16'd0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            emitted_reg  <= emitted_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= o_byte;
            m_tuser_reg <= {o_trunc, o_nodata};
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a bare end marker or a truncation flag only rides on the last result
    a_flags_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> m_tlast)
        else $error("no_data or truncated outside end of message");

    // loading a message end clears the per-message counters
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && o_last) |=> (emitted_reg == 16'd0 && !hit_reg && idx_reg == 2'd0))
        else $error("message counters not cleared at end of message");

endmodule
